/* src/owc_pkg.sv */
// ----------------------------------------------------------------------------
// owc_pkg: shared types and constants of the occupancy window check
// Payload structs, configuration indexes and reset values, grid store size,
// and the scanner's settings struct and its read request to the grid memory.
// ----------------------------------------------------------------------------
`default_nettype none

package owc_pkg;

    // Grid store geometry.
    localparam int GRID_AW    = 16;
    localparam int GRID_CELLS = 1 << GRID_AW;
    localparam int MAX_MARGIN = 7;

    // Configuration port.
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 32;

    localparam logic [CFG_IW-1:0] CFG_GRID_COLUMNS = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_GRID_ROWS    = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_ORIGIN_X     = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_ORIGIN_Y     = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_CELL_SIZE    = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_MARGIN       = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_THRESHOLD    = 3'd6;

    localparam logic [10:0] RST_GRID_COLUMNS = 11'd256;
    localparam logic [10:0] RST_GRID_ROWS    = 11'd256;
    localparam logic [30:0] RST_CELL_SIZE    = 31'd3277;

    // Request kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [15:0]       cell_index;
        logic signed [7:0] cell_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } t_in_item;

    typedef struct packed {
        logic occupied;
        logic outside_grid;
    } t_out_item;

    // Scan settings handed from the configuration registers to the scanner.
    typedef struct packed {
        logic [10:0]       cols;
        logic [10:0]       rows;
        logic [2:0]        margin;
        logic signed [7:0] threshold;
    } t_scan_cfg;

    // Read request from the scanner to the grid memory.
    typedef struct packed {
        logic               en;
        logic [GRID_AW-1:0] addr;
    } t_rd_req;

endpackage

`default_nettype wire

/* src/occupancy_window_check.sv */
// ----------------------------------------------------------------------------
// occupancy_window_check: occupancy grid with a neighborhood query
// Holds a signed 8-bit occupancy grid and answers whether the window of
// plus or minus margin cells around a world position holds an occupied cell.
// Input channel (i_in_valid / o_in_stall) carries one request per accept.
// A write request stores one grid cell in the accepting cycle and gives no
// result. A query request gives one result on the output channel
// (o_out_valid / i_out_stall): occupied and outside_grid.
// A query goes from accept through a start step for the dividers, the two
// bit-serial dividers that turn the coordinate differences into grid cells,
// the window scan at one window cell per cycle through the grid memory read
// port, the scanner pipeline drain and the load of the output register.
// A write leaves the block ready for the next request. Input is stalled
// while a query is in progress; one request is worked on at a time.
// The result sits in an output register; a new request is accepted while
// it waits. When the receiver stalls and a second result is ready, it is
// held in the scanner and input stays stalled until the register frees.
// Reset restores the configuration defaults and empties the output; the
// grid contents are undefined until written. The user must write the
// configuration through i_cfg_we / i_cfg_index / i_cfg_data only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module occupancy_window_check (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [owc_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [owc_pkg::CFG_DW-1:0] i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire owc_pkg::t_in_item          i_in_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output owc_pkg::t_out_item              o_out_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_DIV  = 5'b00100,
        S_SCAN = 5'b01000,
        S_WAIT = 5'b10000
    } t_state;

    t_state r_state;

    logic [10:0]        r_cols;
    logic [10:0]        r_rows;
    logic signed [31:0] r_origin_x;
    logic signed [31:0] r_origin_y;
    logic [30:0]        r_cell_size;
    logic [2:0]         r_margin;
    logic signed [7:0]  r_threshold;

    logic signed [32:0] r_diff_x;
    logic signed [32:0] r_diff_y;
    logic               r_out_valid;
    owc_pkg::t_out_item r_out_data;

    logic               in_accept;
    logic               mem_we;
    logic               div_start;
    logic [30:0]        divisor;
    logic               div_done_x;
    logic               div_done_y;
    logic signed [32:0] quot_x;
    logic signed [32:0] quot_y;
    logic               scan_start;
    logic               scan_done;
    logic               scan_occ;
    logic               scan_outside;
    logic               out_free;
    logic               out_load;
    logic [7:0]         rd_data;
    owc_pkg::t_scan_cfg scan_cfg;
    owc_pkg::t_rd_req   rd_req;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign mem_we     = in_accept && (i_in_data.kind == owc_pkg::KIND_WRITE);
    assign div_start  = (r_state == S_PREP);
    assign divisor    = (r_cell_size == 31'd0) ? 31'd1 : r_cell_size;
    assign scan_start = (r_state == S_DIV) && div_done_x;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign out_load   = out_free &&
                        ((r_state == S_SCAN && scan_done) || r_state == S_WAIT);

    assign scan_cfg.cols      = r_cols;
    assign scan_cfg.rows      = r_rows;
    assign scan_cfg.margin    = r_margin;
    assign scan_cfg.threshold = r_threshold;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols      <= owc_pkg::RST_GRID_COLUMNS;
            r_rows      <= owc_pkg::RST_GRID_ROWS;
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_cell_size <= owc_pkg::RST_CELL_SIZE;
            r_margin    <= '0;
            r_threshold <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                owc_pkg::CFG_GRID_COLUMNS: r_cols      <= i_cfg_data[10:0];
                owc_pkg::CFG_GRID_ROWS:    r_rows      <= i_cfg_data[10:0];
                owc_pkg::CFG_ORIGIN_X:     r_origin_x  <= $signed(i_cfg_data);
                owc_pkg::CFG_ORIGIN_Y:     r_origin_y  <= $signed(i_cfg_data);
                owc_pkg::CFG_CELL_SIZE:    r_cell_size <= i_cfg_data[30:0];
                owc_pkg::CFG_MARGIN:       r_margin    <= i_cfg_data[2:0];
                owc_pkg::CFG_THRESHOLD:    r_threshold <= $signed(i_cfg_data[7:0]);
                default: begin
                end
            endcase
        end
    end

    // Request sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept && i_in_data.kind == owc_pkg::KIND_QUERY) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done_x) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_done) begin
                        r_state <= out_free ? S_IDLE : S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Differences are exact at 33 bits.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_diff_x <= {i_in_data.pos_x[31], i_in_data.pos_x} -
                        {r_origin_x[31], r_origin_x};
            r_diff_y <= {i_in_data.pos_y[31], i_in_data.pos_y} -
                        {r_origin_y[31], r_origin_y};
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data.occupied     <= scan_occ;
            r_out_data.outside_grid <= scan_outside;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    owc_divider u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_diff_x),
        .i_divisor  (divisor),
        .o_done     (div_done_x),
        .o_quot     (quot_x)
    );

    owc_divider u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_diff_y),
        .i_divisor  (divisor),
        .o_done     (div_done_y),
        .o_quot     (quot_y)
    );

    owc_grid_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (i_in_data.cell_index[owc_pkg::GRID_AW-1:0]),
        .i_wdata (i_in_data.cell_value),
        .i_rd    (rd_req),
        .o_rdata (rd_data)
    );

    owc_scanner u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (scan_start),
        .i_mx      (quot_x),
        .i_my      (quot_y),
        .i_cfg     (scan_cfg),
        .i_rd_data (rd_data),
        .o_rd      (rd_req),
        .o_done    (scan_done),
        .o_occ     (scan_occ),
        .o_outside (scan_outside)
    );

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done_x == div_done_y)
        else $error("axis dividers out of step");

    a_scan_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_done |-> (r_state == S_SCAN))
        else $error("scan finished outside the scan state");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_SCAN || r_state == S_WAIT))
        else $error("result loaded without a finished scan");

endmodule

`default_nettype wire

/* src/owc_divider.sv */
// ----------------------------------------------------------------------------
// owc_divider: iterative signed-by-positive divider
// Restoring division of a 33-bit signed dividend by a 31-bit positive
// divisor, one quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module owc_divider (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [32:0] i_dividend,
    input  wire logic [30:0]        i_divisor,
    output logic                    o_done,
    output logic signed [32:0]      o_quot
);

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [30:0] r_rem;
    logic [31:0] r_quo;
    logic [30:0] r_div;
    logic        r_neg;
    logic        r_done;

    logic signed [32:0] mag_w;
    logic [31:0]        trial;
    logic [31:0]        diff;
    logic               ge;

    // The dividend magnitude stays below 2**32, so 32 steps cover it.
    assign mag_w = i_dividend[32] ? -i_dividend : i_dividend;
    assign trial = {r_rem, r_quo[31]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[32];
            r_quo <= mag_w[31:0];
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[30:0] : trial[30:0];
            r_quo <= {r_quo[30:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

endmodule

`default_nettype wire

/* src/owc_grid_mem.sv */
// ----------------------------------------------------------------------------
// owc_grid_mem: occupancy grid store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module owc_grid_mem (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [owc_pkg::GRID_AW-1:0] i_waddr,
    input  wire logic [7:0]                  i_wdata,
    input  wire owc_pkg::t_rd_req            i_rd,
    output logic [7:0]                       o_rdata
);

    logic [7:0] r_mem [owc_pkg::GRID_CELLS];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/owc_scanner.sv */
// ----------------------------------------------------------------------------
// owc_scanner: window scan sequencer
// Walks the square window around a grid cell, one cell per cycle, through a
// three-stage pipeline: bounds check, address and memory read, threshold test.
// ----------------------------------------------------------------------------
`default_nettype none

module owc_scanner (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [32:0] i_mx,
    input  wire logic signed [32:0] i_my,
    input  wire owc_pkg::t_scan_cfg i_cfg,
    input  wire logic [7:0]         i_rd_data,
    output owc_pkg::t_rd_req        o_rd,
    output logic                    o_done,
    output logic                    o_occ,
    output logic                    o_outside
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state r_state;

    logic signed [32:0] r_mx;
    logic signed [32:0] r_my;
    logic [3:0]         r_i;
    logic [3:0]         r_j;
    logic               r_v1;
    logic               r_out1;
    logic [10:0]        r_col1;
    logic [10:0]        r_row1;
    logic               r_v2;
    logic               r_occ;
    logic               r_outside;
    logic               r_done;

    logic [3:0]         two_m;
    logic signed [4:0]  off_x;
    logic signed [4:0]  off_y;
    logic signed [33:0] col_w;
    logic signed [33:0] row_w;
    logic               col_out;
    logic               row_out;
    logic [21:0]        addr_w;
    logic               in_store;

    assign two_m = {i_cfg.margin, 1'b0};
    assign off_x = $signed({1'b0, r_i}) - $signed({2'b00, i_cfg.margin});
    assign off_y = $signed({1'b0, r_j}) - $signed({2'b00, i_cfg.margin});
    assign col_w = {r_mx[32], r_mx} + {{29{off_x[4]}}, off_x};
    assign row_w = {r_my[32], r_my} + {{29{off_y[4]}}, off_y};

    // A negative coordinate is caught by its sign; otherwise the low bits
    // compare unsigned against the grid size.
    assign col_out = col_w[33] || (col_w[32:0] >= {22'b0, i_cfg.cols});
    assign row_out = row_w[33] || (row_w[32:0] >= {22'b0, i_cfg.rows});

    assign addr_w   = (r_row1 * i_cfg.cols) + {11'b0, r_col1};
    assign in_store = addr_w < 22'(owc_pkg::GRID_CELLS);

    assign o_rd.en   = r_v1 && !r_out1 && in_store;
    assign o_rd.addr = addr_w[owc_pkg::GRID_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_v2   <= o_rd.en;
            r_v1   <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_v1 <= 1'b1;
                    if (r_j == two_m && r_i == two_m) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_v1 && !r_v2) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_mx      <= i_mx;
            r_my      <= i_my;
            r_i       <= '0;
            r_j       <= '0;
            r_occ     <= 1'b0;
            r_outside <= 1'b0;
        end else begin
            if (r_state == S_SCAN) begin
                if (r_j == two_m) begin
                    r_j <= '0;
                    r_i <= r_i + 4'd1;
                end else begin
                    r_j <= r_j + 4'd1;
                end
            end
            if (r_v1 && (r_out1 || !in_store)) begin
                r_outside <= 1'b1;
            end
            if (r_v2 && ($signed(i_rd_data) >= i_cfg.threshold)) begin
                r_occ <= 1'b1;
            end
        end
        r_out1 <= col_out || row_out;
        r_col1 <= col_w[10:0];
        r_row1 <= row_w[10:0];
    end

    assign o_done    = r_done;
    assign o_occ     = r_occ;
    assign o_outside = r_outside;

    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd.en |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("grid read issued outside a scan");

    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!r_v1 && !r_v2 && r_state == S_IDLE))
        else $error("scan finished with reads in flight");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("scan left without draining");

endmodule

`default_nettype wire

/* verif/occupancy_window_check_test.sv */
// ----------------------------------------------------------------------------
// occupancy_window_check_test: self-checking bench for the occupancy window check
// Drives cell writes and position queries through the request channel, keeps
// its own copy of the grid and settings, predicts the answer of every query and
// compares it with each result. Runs a short directed sequence on the reset
// settings, then random traffic under several grid settings with random idling.
// ----------------------------------------------------------------------------

module occupancy_window_check_test;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_CYCLES  = 300;
    localparam int SHOWN_ERRORS  = 10;

    localparam int IDLE_NONE  = 0;
    localparam int IDLE_LIGHT = 1;
    localparam int IDLE_HEAVY = 2;

    typedef struct {
        int                 cols;
        int                 rows;
        logic signed [31:0] org_x;
        logic signed [31:0] org_y;
        logic [30:0]        span;
        int                 margin;
        logic signed [7:0]  thresh;
    } t_grid_setup;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [owc_pkg::CFG_IW-1:0]   i_cfg_index = '0;
    logic [owc_pkg::CFG_DW-1:0]   i_cfg_data = '0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    owc_pkg::t_in_item            i_in_data = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    owc_pkg::t_out_item           o_out_data;

    occupancy_window_check dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    t_grid_setup        setup;
    logic signed [7:0]  grid_copy [owc_pkg::GRID_CELLS];
    bit                 filled [owc_pkg::GRID_CELLS];
    owc_pkg::t_in_item  pending_requests [$];
    owc_pkg::t_out_item answers_due [$];
    owc_pkg::t_in_item  req_cur = '0;
    logic               in_fire = 1'b0;
    int                 idle_mode = IDLE_NONE;
    int                 gap_left = 0;
    int                 stall_left = 0;
    int                 failures = 0;
    int                 writes_seen = 0;
    int                 queries_seen = 0;
    int                 answers_checked = 0;
    int                 occupied_seen = 0;
    int                 outside_seen = 0;
    int                 settings_used = 1;
    int                 cycles = 0;

    // Grid cell along one axis: the offset from the corner divided by the
    // cell edge, truncated toward zero. A zero edge counts as one.
    function automatic longint grid_cell_of(logic signed [31:0] pos,
                                            logic signed [31:0] org,
                                            logic [30:0] cs);
        longint span;
        span = (cs == 0) ? 64'sd1 : longint'(cs);
        return (longint'(pos) - longint'(org)) / span;
    endfunction

    // Linear address of a window cell, or 0 when it lies off the grid or the store.
    function automatic bit window_addr(longint col, longint row, output int addr);
        longint lin;
        addr = 0;
        if (col < 0 || row < 0 || col >= longint'(setup.cols) || row >= longint'(setup.rows))
            return 1'b0;
        lin = row * longint'(setup.cols) + col;
        if (lin >= longint'(owc_pkg::GRID_CELLS))
            return 1'b0;
        addr = int'(lin);
        return 1'b1;
    endfunction

    function automatic owc_pkg::t_out_item answer_query(owc_pkg::t_in_item req);
        longint             mx;
        longint             my;
        int                 addr;
        owc_pkg::t_out_item res;
        res = '0;
        mx = grid_cell_of(req.pos_x, setup.org_x, setup.span);
        my = grid_cell_of(req.pos_y, setup.org_y, setup.span);
        for (int dx = -setup.margin; dx <= setup.margin; dx++) begin
            for (int dy = -setup.margin; dy <= setup.margin; dy++) begin
                if (!window_addr(mx + dx, my + dy, addr))
                    res.outside_grid = 1'b1;
                else if (grid_copy[addr] >= setup.thresh)
                    res.occupied = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic void record_request(owc_pkg::t_in_item req);
        if (req.kind == owc_pkg::KIND_QUERY) begin
            answers_due = {answers_due, answer_query(req)};
            queries_seen++;
        end else begin
            grid_copy[req.cell_index] = req.cell_value;
            writes_seen++;
        end
    endfunction

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (idle_mode == IDLE_NONE)
            return 0;
        if (r < ((idle_mode == IDLE_HEAVY) ? 30 : 65))
            return 0;
        if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // Cell values mostly sit below the threshold so that wide windows do not
    // always come back occupied.
    function automatic logic [7:0] pick_value();
        int dens;
        dens = 60 / ((2 * setup.margin + 1) * (2 * setup.margin + 1)) + 2;
        if ($urandom_range(0, 99) < dens || setup.thresh == -8'sd128)
            return 8'($urandom);
        return 8'(int'($urandom_range(0, int'(setup.thresh) + 127)) - 128);
    endfunction

    // Position whose cell mostly lies in or a little beyond the grid along one axis.
    function automatic logic signed [31:0] pos_near(int cells, logic signed [31:0] org);
        longint span;
        longint c;
        longint p;
        span = (setup.span == 0) ? 64'sd1 : longint'(setup.span);
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        c = longint'($urandom_range(0, cells + 2 * setup.margin + 3)) - setup.margin - 2;
        p = longint'(org) + c * span + longint'($urandom_range(0, 32'(span - 1)));
        if (p < -(64'sd1 <<< 31) || p > (64'sd1 <<< 31) - 1)
            return $urandom;
        return 32'(p);
    endfunction

    task automatic queue_write(int idx, logic [7:0] value);
        owc_pkg::t_in_item req;
        req = '0;
        req.kind = owc_pkg::KIND_WRITE;
        req.cell_index = 16'(idx);
        req.cell_value = value;
        req.pos_x = $urandom;
        req.pos_y = $urandom;
        filled[16'(idx)] = 1'b1;
        pending_requests = {pending_requests, req};
    endtask

    // Every in-grid window cell that has never been written gets a write
    // queued ahead of the query, so no query reads an unwritten cell.
    task automatic queue_query(logic signed [31:0] px, logic signed [31:0] py);
        longint            mx;
        longint            my;
        int                addr;
        owc_pkg::t_in_item req;
        mx = grid_cell_of(px, setup.org_x, setup.span);
        my = grid_cell_of(py, setup.org_y, setup.span);
        for (int dx = -setup.margin; dx <= setup.margin; dx++) begin
            for (int dy = -setup.margin; dy <= setup.margin; dy++) begin
                if (window_addr(mx + dx, my + dy, addr) && !filled[addr])
                    queue_write(addr, pick_value());
            end
        end
        req = '0;
        req.kind = owc_pkg::KIND_QUERY;
        req.cell_index = 16'($urandom);
        req.cell_value = 8'($urandom);
        req.pos_x = px;
        req.pos_y = py;
        pending_requests = {pending_requests, req};
    endtask

    task automatic wait_drained(int tail);
        while (pending_requests.size() != 0 || i_in_valid || answers_due.size() != 0)
            @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_setting(logic [owc_pkg::CFG_IW-1:0] idx,
                                 logic [owc_pkg::CFG_DW-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int cols, int rows, logic [31:0] ox, logic [31:0] oy,
                             logic [30:0] cs, int mg, logic [7:0] th, int n, int mode);
        int addr;
        wait_drained(SETTLE_CYCLES);
        write_setting(owc_pkg::CFG_GRID_COLUMNS, 32'(cols));
        write_setting(owc_pkg::CFG_GRID_ROWS, 32'(rows));
        write_setting(owc_pkg::CFG_ORIGIN_X, ox);
        write_setting(owc_pkg::CFG_ORIGIN_Y, oy);
        write_setting(owc_pkg::CFG_CELL_SIZE, {1'b0, cs});
        write_setting(owc_pkg::CFG_MARGIN, 32'(mg));
        write_setting(owc_pkg::CFG_THRESHOLD, {{24{th[7]}}, th});
        setup.cols = cols;
        setup.rows = rows;
        setup.org_x = ox;
        setup.org_y = oy;
        setup.span = cs;
        setup.margin = mg;
        setup.thresh = th;
        idle_mode = mode;
        settings_used++;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 40) begin
                queue_query(pos_near(cols, setup.org_x), pos_near(rows, setup.org_y));
            end else if ($urandom_range(0, 9) < 7 && cols > 0 && rows > 0 &&
                         window_addr($urandom_range(0, cols - 1), $urandom_range(0, rows - 1),
                                     addr)) begin
                queue_write(addr, pick_value());
            end else begin
                queue_write($urandom_range(0, owc_pkg::GRID_CELLS - 1), 8'($urandom));
            end
        end
    endtask

    // A request counts as taken at the edge where valid is high and stall low.
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_in_valid && !o_in_stall;
    end

    always @(negedge i_clk) begin : drive_requests
        if (in_fire)
            record_request(req_cur);
        if (!i_in_valid || in_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                req_cur = pending_requests.pop_front();
                i_in_data <= req_cur;
                i_in_valid <= 1'b1;
                gap_left = pause_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : pace_results
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left <= pause_len();
        end
    end

    always @(posedge i_clk) begin : check_answers
        owc_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            answers_checked++;
            if (o_out_data.occupied === 1'b1)
                occupied_seen++;
            if (o_out_data.outside_grid === 1'b1)
                outside_seen++;
            if (answers_due.size() == 0) begin
                failures++;
                if (failures <= SHOWN_ERRORS)
                    $display("ERROR: result occupied=%b outside=%b with no query waiting",
                             o_out_data.occupied, o_out_data.outside_grid);
            end else begin
                want = answers_due.pop_front();
                if (o_out_data.occupied !== want.occupied ||
                    o_out_data.outside_grid !== want.outside_grid) begin
                    failures++;
                    if (failures <= SHOWN_ERRORS)
                        $display("ERROR: result %0d occupied exp %b got %b, outside exp %b got %b",
                                 answers_checked, want.occupied, o_out_data.occupied,
                                 want.outside_grid, o_out_data.outside_grid);
                end
            end
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("ERROR: run stopped after %0d cycles", CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        setup.cols = owc_pkg::RST_GRID_COLUMNS;
        setup.rows = owc_pkg::RST_GRID_ROWS;
        setup.org_x = '0;
        setup.org_y = '0;
        setup.span = owc_pkg::RST_CELL_SIZE;
        setup.margin = 0;
        setup.thresh = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: store extremes, truncation toward zero just below
        // the corner, the last cell of the store and positions far off the grid.
        idle_mode = IDLE_LIGHT;
        queue_write(0, 8'sh7F);
        queue_write(owc_pkg::GRID_CELLS - 1, 8'sh80);
        queue_write(257, 8'shFF);
        queue_query(32'sd0, 32'sd0);
        queue_query(-32'sd1, -32'sd1);
        queue_query(-32'sd3277, 32'sd0);
        queue_query(32'sd3277, 32'sd3277);
        queue_query(32'sd255 * 32'sd3277 + 32'sd3276, 32'sd255 * 32'sd3277 + 32'sd3276);
        queue_query(32'sd256 * 32'sd3277, 32'sd0);
        queue_query(32'sh7FFF_FFFF, 32'sh8000_0000);
        queue_query(32'sh8000_0000, 32'sh7FFF_FFFF);

        run_phase(16, 16, 0, 0, 31'h1_0000, 1, 8'sd0, 40, IDLE_LIGHT);
        run_phase(1, 1, -32'sd655360, 32'sd0, 31'd1, 7, 8'sh80, 30, IDLE_HEAVY);
        run_phase(1024, 64, 32'h0012_3456, -32'sd300000, 31'd3277, 0, 8'sd50, 40, IDLE_NONE);
        run_phase(0, 5, 0, 0, 31'd3277, 2, 8'sd0, 20, IDLE_LIGHT);
        // Zero cell edge and corners at the ends of the range: differences
        // need the full 33 bits.
        run_phase(2047, 2047, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0, 7, 8'sh7F, 30, IDLE_LIGHT);
        run_phase(10, 8, -32'sd229376, 32'sd147456, 31'h7FFF_FFFF, 5, 8'shFF, 30, IDLE_HEAVY);
        repeat (4) begin
            run_phase($urandom_range(1, 12), $urandom_range(1, 12),
                      32'(int'($urandom_range(0, 2_000_000)) - 1_000_000),
                      32'(int'($urandom_range(0, 2_000_000)) - 1_000_000),
                      31'($urandom_range(2048, 131072)), $urandom_range(0, 7),
                      8'($urandom), 30, $urandom_range(IDLE_NONE, IDLE_HEAVY));
        end

        wait_drained(DRAIN_CYCLES);
        failures += answers_due.size();
        $display("Ran %0d cell writes and %0d queries under %0d grid settings.",
                 writes_seen, queries_seen, settings_used);
        $display("Checked %0d answers: %0d occupied, %0d touching cells off the grid.",
                 answers_checked, occupied_seen, outside_seen);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
